// ===== rtl/utf8_coded_number_decoder_top_defines.svh =====
// Assertion macros used by u8cnd_core.
// U8CND_ASSERT checks a property outside reset, U8CND_ASSERT_ALWAYS checks it at every edge.
`ifndef UTF8_CODED_NUMBER_DECODER_TOP_DEFINES_SVH
`define UTF8_CODED_NUMBER_DECODER_TOP_DEFINES_SVH
`ifndef SYNTH
`define U8CND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define U8CND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8CND_ASSERT(lbl, prop, msg)
`define U8CND_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/u8cnd_pkg.sv =====
`default_nettype none

package u8cnd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 36;
  localparam int REM_W   = 3;
  localparam int DIGIT_W = 6;

  // Continuation byte tag in bits 7:6
  localparam logic [1:0] CONT_TAG = 2'b10;
  // Lead count meaning "no clear bit found"
  localparam logic [REM_W-1:0] LEAD_BAD  = 3'd0;
  // Six continuations, only legal in wide mode
  localparam logic [REM_W-1:0] LEAD_WIDE = 3'd6;
  localparam logic [REM_W-1:0] REM_IDLE  = 3'd0;
  localparam logic [REM_W-1:0] REM_LAST  = 3'd1;

  localparam logic [VALUE_W-1:0] VALUE_ERR = {VALUE_W{1'b1}};

  // APB register index
  localparam logic REG_WIDE_MODE = 1'b0;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               invalid;
  } result_t;

  // Continuation count from the low six bits of a lead byte
  function automatic logic [REM_W-1:0] lead_count(input logic [DIGIT_W-1:0] low);
    logic [REM_W-1:0] k;
    priority if (!low[5]) k = 3'd1;
    else if (!low[4])     k = 3'd2;
    else if (!low[3])     k = 3'd3;
    else if (!low[2])     k = 3'd4;
    else if (!low[1])     k = 3'd5;
    else if (!low[0])     k = 3'd6;
    else                  k = LEAD_BAD;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8cnd_core.sv =====
`default_nettype none
`include "utf8_coded_number_decoder_top_defines.svh"

module u8cnd_core
  import u8cnd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              wide_mode,
  input  wire logic              res_ready,
  output logic                   res_valid,
  output result_t                res
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [REM_W-1:0]  rem, rem_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic              advance;
  logic              emit;
  logic [REM_W-1:0]  k;
  logic [VALUE_W-1:0] acc_shift;

  assign advance  = in_valid_r && res_ready;
  assign in_ready = !in_valid_r || res_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  assign k         = lead_count(in_byte_r[DIGIT_W-1:0]);
  assign acc_shift = {acc[VALUE_W-DIGIT_W-1:0], in_byte_r[DIGIT_W-1:0]};

  // Decode one byte against the sequence state
  always_comb begin
    rem_next    = rem;
    acc_next    = acc;
    emit        = 1'b0;
    res.value   = VALUE_ERR;
    res.invalid = 1'b1;
    if (rem == REM_IDLE) begin
      if (!in_byte_r[7]) begin
        emit        = 1'b1;
        res.value   = VALUE_W'(in_byte_r);
        res.invalid = 1'b0;
      end else if (k == LEAD_BAD || (k == LEAD_WIDE && !wide_mode)) begin
        emit = 1'b1;
      end else begin
        rem_next = k;
        acc_next = VALUE_W'(in_byte_r[DIGIT_W-1:0] & (6'h3F >> k));
      end
    end else if (in_byte_r[7:6] != CONT_TAG) begin
      // bad continuation drops the sequence
      emit     = 1'b1;
      rem_next = REM_IDLE;
    end else begin
      rem_next = rem - REM_LAST;
      acc_next = acc_shift;
      if (rem == REM_LAST) begin
        emit        = 1'b1;
        res.value   = acc_shift;
        res.invalid = 1'b0;
      end
    end
  end

  assign res_valid = advance && emit;

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= REM_IDLE;
    end else if (advance) begin
      rem <= rem_next;
    end
    if (advance) begin
      acc <= acc_next;
    end
  end

  `U8CND_ASSERT_ALWAYS(a_reset_idle, rst |=> (rem == REM_IDLE) && !in_valid_r, "not idle after reset")
  `U8CND_ASSERT(a_error_idle, res_valid && res.invalid |=> rem == REM_IDLE, "error left sequence open")
  `U8CND_ASSERT(a_rem_range, rem <= LEAD_WIDE, "continuation count out of range")

endmodule

`default_nettype wire

// ===== rtl/u8cnd_out_reg.sv =====
`default_nettype none

module u8cnd_out_reg
  import u8cnd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         res_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out
);

  // Register accepts a new result when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_coded_number_decoder_top.sv =====
// Decoder for the variable-length UTF-8 style coded number found in FLAC frame headers.
// Bytes enter on the s_ stream one per transaction; each completed number, or an error for a
// malformed lead or continuation byte, leaves on the m_ stream as one transaction, with the
// value all ones when invalid. One byte is taken every cycle unless the result register is
// held; an accepted byte lands in the input register, is decoded combinationally against the
// sequence state and lands in the result register that drives m_ once that register can
// take it. With the result register held, one more byte fits before s_tready drops.
// wide_mode (APB address 0, reset 1) enables the six-continuation leads 0xFE and 0xBE and is
// sampled at each lead byte; write it only idle.
`default_nettype none

module utf8_coded_number_decoder_top
  import u8cnd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  // result stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [35:0] value, [39:36] zero
  output logic [0:0]       m_tuser    // [0] invalid
);

  logic    wide_mode;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WIDE_MODE) begin
      wide_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDE_MODE) begin
      prdata[0] = wide_mode;
    end
  end

  u8cnd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .wide_mode (wide_mode),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  u8cnd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out       (out)
  );

  assign m_tdata = {4'b0000, out.value};
  assign m_tuser = out.invalid;

endmodule

`default_nettype wire

// ===== test/tb_utf8_coded_number_decoder_top.sv =====
module tb_utf8_coded_number_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8cnd_pkg::*;

  localparam logic [2:0] WIDE_MODE_ADDR = 3'(4 * int'(REG_WIDE_MODE));
  // index 1 has no register behind it; writes there must be ignored
  localparam logic [2:0] SPARE_ADDR     = 3'd4;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         DRAIN_LIMIT    = 5000;
  localparam int         HOLD_CYCLES    = 300;

  // Predicts decoded numbers and checks them against the result stream
  class number_board;
    result_t          expected_q[$];
    bit               wide_mode;
    logic [REM_W-1:0] remaining;
    logic [VALUE_W-1:0] acc;
    int               errors;
    int               n_valid;
    int               n_invalid;

    function new();
      wide_mode = 1'b1;
      remaining = REM_IDLE;
      acc       = '0;
      errors    = 0;
      n_valid   = 0;
      n_invalid = 0;
    endfunction

    function void write_reg(int index, logic [31:0] data);
      if (index == int'(REG_WIDE_MODE)) wide_mode = data[0];
    endfunction

    function void push(logic [VALUE_W-1:0] v, logic bad);
      result_t r;
      r.value   = v;
      r.invalid = bad;
      expected_q.push_back(r);
    endfunction

    // one accepted input transaction
    function void take_byte(logic [7:0] b);
      int k;
      logic [5:0] lead_mask;
      if (remaining == REM_IDLE) begin
        // single-byte number
        if (!b[7]) begin
          acc = '0;
          push(VALUE_W'(b), 1'b0);
          return;
        end
        // first clear bit among 5..0 sets the continuation count
        k = 0;
        for (int p = 5; p >= 0; p--)
          if (k == 0 && !b[p]) k = 6 - p;
        if (k == 0 || (k == 6 && !wide_mode)) begin
          acc = '0;
          push(VALUE_ERR, 1'b1);
          return;
        end
        lead_mask = 6'h3F >> k;
        acc       = VALUE_W'(b[5:0] & lead_mask);
        remaining = REM_W'(k);
      end else if (b[7:6] != CONT_TAG) begin
        // bad continuation drops the sequence
        remaining = REM_IDLE;
        acc       = '0;
        push(VALUE_ERR, 1'b1);
      end else begin
        acc       = {acc[VALUE_W-7:0], b[5:0]};
        remaining = remaining - 1'b1;
        if (remaining == REM_IDLE) begin
          push(acc, 1'b0);
          acc = '0;
        end
      end
    endfunction

    // one accepted output transaction
    function void check_number(logic [VALUE_W-1:0] v, logic bad);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result: value=%h invalid=%0b", v, bad);
        return;
      end
      want = expected_q.pop_front();
      if (v !== want.value) begin
        errors++;
        $error("value mismatch: expected %h, actual %h", want.value, v);
      end
      if (bad !== want.invalid) begin
        errors++;
        $error("invalid mismatch: expected %0b, actual %0b", want.invalid, bad);
      end
      if (want.invalid) n_invalid++;
      else n_valid++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $error("%0d expected results never arrived", expected_q.size());
        expected_q.delete();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [35:0] value, [39:36] zero
  logic [0:0]  m_tuser;   // [0] invalid

  number_board sb;
  int  send_idle = 37;
  int  recv_idle = 45;
  int  bytes_sent = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  utf8_coded_number_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_number(m_tdata[VALUE_W-1:0], m_tuser[0]);
  end

  initial begin
    #2_000_000;
    $display("tb_utf8_coded_number_decoder_top: done, errors");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // fill: 0 all-zero payload, 1 all-ones payload, else random
  function automatic logic [7:0] make_lead(int k, int fill);
    int p;
    logic [5:0] ones, low;
    p    = 6 - k;
    ones = 6'h3F << (p + 1);
    low  = (fill == 0) ? 6'h00 : (fill == 1) ? 6'h3F : 6'($urandom);
    low  = low & ~(6'h3F << p);
    return {1'b1, 1'($urandom), ones | low};
  endfunction

  function automatic logic [7:0] make_cont(int fill);
    return {CONT_TAG, (fill == 0) ? 6'h00 : (fill == 1) ? 6'h3F : 6'($urandom)};
  endfunction

  task automatic send_number();
    int k, fill;
    k    = sb.wide_mode ? $urandom_range(6, 1) : $urandom_range(5, 1);
    fill = $urandom_range(3);
    send_byte(make_lead(k, fill));
    repeat (k) send_byte(make_cont(fill));
  endtask

  // bad lead, or a sequence cut short by a non-continuation byte
  task automatic send_broken();
    int k, good;
    logic [1:0] tag;
    if ($urandom_range(3) == 0) begin
      if (!sb.wide_mode && $urandom_range(1)) send_byte({1'b1, 1'($urandom), 6'h3E});
      else send_byte({1'b1, 1'($urandom), 6'h3F});
    end else begin
      k    = sb.wide_mode ? $urandom_range(6, 1) : $urandom_range(5, 1);
      good = $urandom_range(k - 1);
      send_byte(make_lead(k, 2));
      repeat (good) send_byte(make_cont(2));
      tag = 2'($urandom_range(2));
      if (tag == CONT_TAG) tag = 2'b11;
      send_byte({tag, 6'($urandom)});
    end
  endtask

  task automatic random_mix(int count, bit with_hold);
    int stop_at, r;
    bit held;
    stop_at = bytes_sent + count;
    held    = 1'b0;
    while (bytes_sent < stop_at) begin
      // one long receiver hold-off once the run is under way
      if (with_hold && !held && bytes_sent >= stop_at - count + 60) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 15) send_byte(8'($urandom_range(127)));
      else if (r < 75) send_number();
      else if (r < 88) send_broken();
      else send_byte(8'($urandom));
    end
  endtask

  // drop valid, wait for outstanding results, then let the pipeline settle
  task automatic wait_settled();
    int n;
    n = 0;
    s_tvalid = 1'b0;
    while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr >> 2, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // write wide_mode and read it back
  task automatic set_wide_mode(bit m);
    logic [31:0] rd;
    apb_write(WIDE_MODE_ADDR, {31'b0, m});
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = WIDE_MODE_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd !== {31'b0, m}) begin
      sb.errors++;
      $error("wide_mode readback mismatch: expected %h, actual %h", {31'b0, m}, rd);
    end
  endtask

  // idle knobs change just after a rising edge, away from the receiver's edge
  task automatic set_idle(int tx, int rx);
    @(posedge clk);
    send_idle = tx;
    recv_idle = rx;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] seq[$];
    sb       = new();
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, bit-6-clear lead, bad leads, bad continuation
    set_wide_mode(1'b1);
    seq = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'h85, 8'h80,
            8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
            8'hFF, 8'hBF, 8'hE0, 8'h41};
    foreach (seq[i]) send_byte(seq[i]);

    // mode drops to narrow after a wide lead: the open sequence still completes
    send_byte(8'hFE);
    wait_settled();
    set_wide_mode(1'b0);
    repeat (6) send_byte(8'hBF);
    // wide leads now rejected
    send_byte(8'hFE);
    send_byte(8'hBE);
    wait_settled();
    set_wide_mode(1'b1);

    // receiver idles more than sender
    random_mix(310, 1'b0);
    wait_settled();

    // narrow mode, idle pattern swapped; unused address written too
    apb_write(SPARE_ADDR, 32'h0000_0001);
    set_wide_mode(1'b0);
    set_idle(45, 37);
    random_mix(310, 1'b0);
    wait_settled();

    // wide mode, no idling, one long receiver hold-off
    set_wide_mode(1'b1);
    set_idle(0, 0);
    random_mix(310, 1'b1);

    wait_settled();
    sb.report_leftover();

    $display("%0d bytes sent over three idle patterns, wide mode on and off, one long stall",
             bytes_sent);
    $display("%0d numbers and %0d error results checked", sb.n_valid, sb.n_invalid);
    if (sb.errors == 0) begin
      $display("tb_utf8_coded_number_decoder_top: done, clean");
    end else begin
      $display("tb_utf8_coded_number_decoder_top: done, errors");
    end
    $finish;
  end

endmodule
